### rtl/nerp_pkg.sv
package nerp_pkg;

    localparam int CHANNELS_DEF = 16;
    localparam int EVENTS_DEF   = 256;

    localparam int OP_W   = 3;
    localparam int STEP_W = 32;
    localparam int CH_W   = 4;
    localparam int NOTE_W = 7;
    localparam int VEL_W  = 7;

    typedef enum logic [OP_W-1:0] {
        OP_REC_START  = 3'd0,
        OP_REC_STOP   = 3'd1,
        OP_PLAY_START = 3'd2,
        OP_PLAY_STOP  = 3'd3,
        OP_REC_NOTE   = 3'd4,
        OP_FETCH      = 3'd5
    } t_op;

    typedef struct packed {
        logic [STEP_W-1:0] rel_step;
        logic [NOTE_W-1:0] note;
        logic [VEL_W-1:0]  velocity;
    } t_entry;

    typedef struct packed {
        logic              found;
        logic              is_note_on;
        logic [CH_W-1:0]   channel;
        logic [NOTE_W-1:0] note;
        logic [VEL_W-1:0]  velocity;
        logic [STEP_W-1:0] step;
        logic              overflow;
    } t_result;

endpackage

### rtl/nerp_if.sv
interface nerp_in_if;
    import nerp_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [STEP_W-1:0] current_step;
    logic [CH_W-1:0]   channel;
    logic              is_note_on;
    logic [NOTE_W-1:0] note_number;
    logic [VEL_W-1:0]  note_velocity;

    modport source (
        output valid, operation, current_step, channel, is_note_on, note_number,
               note_velocity,
        input  ready
    );
    modport sink (
        input  valid, operation, current_step, channel, is_note_on, note_number,
               note_velocity,
        output ready
    );
endinterface

interface nerp_out_if;
    import nerp_pkg::*;

    logic              valid;
    logic              ready;
    logic              found;
    logic              out_is_note_on;
    logic [CH_W-1:0]   out_channel;
    logic [NOTE_W-1:0] out_note;
    logic [VEL_W-1:0]  out_velocity;
    logic [STEP_W-1:0] out_step;
    logic              overflow;

    modport source (
        output valid, found, out_is_note_on, out_channel, out_note, out_velocity,
               out_step, overflow,
        input  ready
    );
    modport sink (
        input  valid, found, out_is_note_on, out_channel, out_note, out_velocity,
               out_step, overflow,
        output ready
    );
endinterface

### rtl/nerp_alu.sv
module nerp_alu (
    input  logic [nerp_pkg::STEP_W-1:0] i_a,
    input  logic [nerp_pkg::STEP_W-1:0] i_b,
    output logic [nerp_pkg::STEP_W-1:0] o_diff,
    output logic                        o_borrow
);
    import nerp_pkg::*;

    logic [STEP_W:0] w_full;

    assign w_full   = {1'b0, i_a} - {1'b0, i_b};
    assign o_diff   = w_full[STEP_W-1:0];
    assign o_borrow = w_full[STEP_W];

endmodule

### rtl/nerp_store.sv
module nerp_store #(
    parameter int AW = 12
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  nerp_pkg::t_entry i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output nerp_pkg::t_entry o_rdata
);
    import nerp_pkg::*;

    t_entry r_mem [2**AW];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/note_event_record_playback.sv
// Note recorder and player for CHANNELS channels, each with one note-on and one
// note-off list of EVENTS_PER_CHANNEL entries held in two block memories. The
// block takes one word at a time. A record-note word goes through the record
// state and then the emit state, which loads the output register; a fetch word
// scans the channels in turn, each channel costing two passes through the one
// 32-bit subtractor that forms relative times and does every due-time compare,
// and the next channel's list heads are read from the memories while the
// on-list of the current one is compared. A finished result waits in the
// output register while the next word is taken. The event memories need no
// clearing after reset: only entries below a list's count are ever read.
module note_event_record_playback #(
    parameter int CHANNELS           = nerp_pkg::CHANNELS_DEF,
    parameter int EVENTS_PER_CHANNEL = nerp_pkg::EVENTS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    nerp_in_if.sink    i_in,
    nerp_out_if.source o_out
);
    import nerp_pkg::*;

    localparam int CHW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int IW  = $clog2(EVENTS_PER_CHANNEL);
    localparam int CW  = $clog2(EVENTS_PER_CHANNEL + 1);
    localparam int AW  = CHW + IW;
    localparam logic [CHW-1:0] CH_LAST  = CHW'(CHANNELS - 1);
    localparam logic [CW-1:0]  CNT_FULL = CW'(EVENTS_PER_CHANNEL);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_REC  = 6'b000010,
        S_ELAP = 6'b000100,
        S_OFF  = 6'b001000,
        S_ON   = 6'b010000,
        S_EMIT = 6'b100000
    } t_state;

    t_state            r_state;
    logic              r_out_valid;
    logic [CW-1:0]     r_on_cnt  [CHANNELS];
    logic [CW-1:0]     r_off_cnt [CHANNELS];
    logic [CW-1:0]     r_on_pos  [CHANNELS];
    logic [CW-1:0]     r_off_pos [CHANNELS];
    logic [STEP_W-1:0] r_record_origin;
    logic              r_play_active;
    logic [STEP_W-1:0] r_play_origin;

    logic [STEP_W-1:0] r_step;
    logic [CH_W-1:0]   r_ch;
    logic              r_is_on;
    logic [NOTE_W-1:0] r_note;
    logic [VEL_W-1:0]  r_vel;
    logic [STEP_W-1:0] r_elapsed;
    logic [CHW-1:0]    r_scan;
    logic              r_on_avail;
    logic              r_off_avail;
    logic [CW-1:0]     r_on_pos_q;
    logic [CW-1:0]     r_off_pos_q;
    t_result           r_res;
    t_result           r_out;

    logic              w_in_acc;
    logic [CHW-1:0]    w_ch_idx;
    logic              w_ch_ok;
    logic [CHW-1:0]    w_rd_ch;
    logic [CHW-1:0]    w_cnt_idx;
    logic [CW-1:0]     w_on_cnt;
    logic [CW-1:0]     w_off_cnt;
    logic [CW-1:0]     w_on_pos;
    logic [CW-1:0]     w_off_pos;
    logic [CW-1:0]     w_rec_cnt;
    logic              w_rec_ok;
    logic              w_rec_full;
    logic              w_rec_wr;
    logic              w_off_due;
    logic              w_on_due;
    logic              w_out_free;
    logic [STEP_W-1:0] w_alu_a;
    logic [STEP_W-1:0] w_alu_b;
    logic [STEP_W-1:0] w_diff;
    logic              w_borrow;
    t_entry            w_wdata;
    t_entry            w_on_rd;
    t_entry            w_off_rd;
    logic [AW-1:0]     w_waddr;
    logic [AW-1:0]     w_on_raddr;
    logic [AW-1:0]     w_off_raddr;

    assign w_in_acc   = i_in.valid && i_in.ready;
    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_ch_idx   = CHW'(r_ch);
    assign w_ch_ok    = int'(r_ch) < CHANNELS;
    assign w_rd_ch    = (r_state == S_ON)  ? CHW'(r_scan + 1'b1) :
                        (r_state == S_OFF) ? r_scan : '0;
    assign w_cnt_idx  = (r_state == S_REC) ? w_ch_idx : w_rd_ch;
    assign w_on_cnt   = r_on_cnt[w_cnt_idx];
    assign w_off_cnt  = r_off_cnt[w_cnt_idx];
    assign w_on_pos   = r_on_pos[w_rd_ch];
    assign w_off_pos  = r_off_pos[w_rd_ch];

    assign w_rec_cnt  = r_is_on ? w_on_cnt : w_off_cnt;
    assign w_rec_ok   = (r_record_origin != '0) && w_ch_ok;
    assign w_rec_full = w_rec_cnt == CNT_FULL;
    assign w_rec_wr   = (r_state == S_REC) && w_rec_ok && !w_rec_full;

    assign w_off_due  = r_off_avail && !w_borrow;
    assign w_on_due   = r_on_avail && !w_borrow;

    always_comb begin
        unique case (r_state)
            S_REC: begin
                w_alu_a = r_step;
                w_alu_b = r_record_origin;
            end
            S_ELAP: begin
                w_alu_a = r_step;
                w_alu_b = r_play_origin;
            end
            S_OFF: begin
                w_alu_a = r_elapsed;
                w_alu_b = w_off_rd.rel_step;
            end
            S_ON: begin
                w_alu_a = r_elapsed;
                w_alu_b = w_on_rd.rel_step;
            end
            default: begin
                w_alu_a = '0;
                w_alu_b = '0;
            end
        endcase
    end

    nerp_alu u_alu (
        .i_a      (w_alu_a),
        .i_b      (w_alu_b),
        .o_diff   (w_diff),
        .o_borrow (w_borrow)
    );

    assign w_waddr     = {w_ch_idx, w_rec_cnt[IW-1:0]};
    assign w_on_raddr  = {w_rd_ch, w_on_pos[IW-1:0]};
    assign w_off_raddr = {w_rd_ch, w_off_pos[IW-1:0]};
    assign w_wdata     = '{rel_step: w_diff, note: r_note, velocity: r_vel};

    nerp_store #(.AW(AW)) u_on_store (
        .i_clk   (i_clk),
        .i_we    (w_rec_wr && r_is_on),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_on_raddr),
        .o_rdata (w_on_rd)
    );

    nerp_store #(.AW(AW)) u_off_store (
        .i_clk   (i_clk),
        .i_we    (w_rec_wr && !r_is_on),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_off_raddr),
        .o_rdata (w_off_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_out_valid     <= 1'b0;
            r_record_origin <= '0;
            r_play_active   <= 1'b0;
            r_play_origin   <= '0;
            for (int c = 0; c < CHANNELS; c++) begin
                r_on_cnt[c]  <= '0;
                r_off_cnt[c] <= '0;
                r_on_pos[c]  <= '0;
                r_off_pos[c] <= '0;
            end
        end else begin
            if (o_out.valid && o_out.ready && (r_state != S_EMIT)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        case (i_in.operation)
                            OP_REC_START: begin
                                r_record_origin <= i_in.current_step;
                                for (int c = 0; c < CHANNELS; c++) begin
                                    r_on_cnt[c]  <= '0;
                                    r_off_cnt[c] <= '0;
                                    r_on_pos[c]  <= '0;
                                    r_off_pos[c] <= '0;
                                end
                            end
                            OP_REC_STOP: begin
                                r_record_origin <= '0;
                            end
                            OP_PLAY_START: begin
                                r_play_origin <= i_in.current_step;
                                r_play_active <= 1'b1;
                                for (int c = 0; c < CHANNELS; c++) begin
                                    r_on_pos[c]  <= '0;
                                    r_off_pos[c] <= '0;
                                end
                            end
                            OP_PLAY_STOP: begin
                                r_play_active <= 1'b0;
                            end
                            OP_REC_NOTE: begin
                                r_state <= S_REC;
                            end
                            OP_FETCH: begin
                                r_state <= r_play_active ? S_ELAP : S_EMIT;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_REC: begin
                    if (w_rec_wr) begin
                        if (r_is_on) begin
                            r_on_cnt[w_ch_idx] <= w_rec_cnt + 1'b1;
                        end else begin
                            r_off_cnt[w_ch_idx] <= w_rec_cnt + 1'b1;
                        end
                    end
                    r_state <= S_EMIT;
                end
                S_ELAP: begin
                    r_state <= S_OFF;
                end
                S_OFF: begin
                    if (w_off_due) begin
                        r_off_pos[r_scan] <= r_off_pos_q + 1'b1;
                        r_state           <= S_EMIT;
                    end else begin
                        r_state <= S_ON;
                    end
                end
                S_ON: begin
                    if (w_on_due) begin
                        r_on_pos[r_scan] <= r_on_pos_q + 1'b1;
                        r_state          <= S_EMIT;
                    end else if (r_scan == CH_LAST) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_OFF;
                    end
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && w_in_acc) begin
            r_step  <= i_in.current_step;
            r_ch    <= i_in.channel;
            r_is_on <= i_in.is_note_on;
            r_note  <= i_in.note_number;
            r_vel   <= i_in.note_velocity;
            r_res   <= '0;
        end
        if ((r_state == S_ELAP) || (r_state == S_ON)) begin
            r_on_avail  <= w_on_pos != w_on_cnt;
            r_off_avail <= w_off_pos != w_off_cnt;
            r_on_pos_q  <= w_on_pos;
            r_off_pos_q <= w_off_pos;
        end
        if (r_state == S_REC) begin
            r_res.overflow <= w_rec_ok && w_rec_full;
        end
        if (r_state == S_ELAP) begin
            r_elapsed <= w_diff;
            r_scan    <= '0;
        end
        if ((r_state == S_OFF) && w_off_due) begin
            r_res <= '{found: 1'b1, is_note_on: 1'b0, channel: CH_W'(r_scan),
                       note: w_off_rd.note, velocity: w_off_rd.velocity,
                       step: r_step, overflow: 1'b0};
        end
        if (r_state == S_ON) begin
            if (w_on_due) begin
                r_res <= '{found: 1'b1, is_note_on: 1'b1, channel: CH_W'(r_scan),
                           note: w_on_rd.note, velocity: w_on_rd.velocity,
                           step: r_step, overflow: 1'b0};
            end else if (r_scan != CH_LAST) begin
                r_scan <= CHW'(r_scan + 1'b1);
            end
        end
        if ((r_state == S_EMIT) && w_out_free) begin
            r_out <= r_res;
        end
    end

    assign i_in.ready           = r_state == S_IDLE;
    assign o_out.valid          = r_out_valid;
    assign o_out.found          = r_out.found;
    assign o_out.out_is_note_on = r_out.is_note_on;
    assign o_out.out_channel    = r_out.channel;
    assign o_out.out_note       = r_out.note;
    assign o_out.out_velocity   = r_out.velocity;
    assign o_out.out_step       = r_out.step;
    assign o_out.overflow       = r_out.overflow;

endmodule
